[src/atdl_pkg.sv]
// Package with the constants, types, tap table and edge-index function of the line filter.
package atdl_pkg;

    localparam int LINE_MAX   = 1024;
    localparam int RING_DEPTH = 128;
    localparam int TAPS       = 7;
    localparam int HALF_TAPS  = TAPS / 2;
    localparam int MAX_SCALE  = 4;

    localparam int SAMPLE_W = 16;
    localparam int VALUE_W  = 25;
    localparam int COEF_W   = 10;
    localparam int RING_AW  = $clog2(RING_DEPTH);
    localparam int CNT_W    = $clog2(LINE_MAX + 1);
    localparam int IDX_W    = CNT_W + 3;
    localparam int TAP_W    = $clog2(TAPS);

    localparam logic [1:0] CFG_FILTER_SELECT = 2'd0;
    localparam logic [1:0] CFG_SCALE         = 2'd1;
    localparam logic [1:0] CFG_BORDER_MODE   = 2'd2;

    localparam logic [2:0] FILT_H  = 3'd0;
    localparam logic [2:0] FILT_G  = 3'd1;
    localparam logic [2:0] FILT_K  = 3'd2;
    localparam logic [2:0] FILT_L  = 3'd3;
    localparam logic [2:0] FILT_HS = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_WAIT,
        ST_OUT
    } state_t;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [VALUE_W-1:0]  value_t;
    typedef logic signed [COEF_W-1:0]   coef_t;

    function automatic coef_t tap_coef(input logic [2:0] sel, input logic [TAP_W-1:0] k);
        coef_t c;
        c = '0;
        case (sel)
            FILT_H:
            begin
                case (k)
                    3'd2, 3'd5: c = 10'sd16;
                    3'd3, 3'd4: c = 10'sd48;
                    default:    c = '0;
                endcase
            end
            FILT_G:
            begin
                case (k)
                    3'd3:    c = -10'sd256;
                    3'd4:    c = 10'sd256;
                    default: c = '0;
                endcase
            end
            FILT_K:
            begin
                case (k)
                    3'd0:    c = 10'sd1;
                    3'd1:    c = 10'sd7;
                    3'd2:    c = 10'sd22;
                    3'd3:    c = -10'sd22;
                    3'd4:    c = -10'sd7;
                    3'd5:    c = -10'sd1;
                    default: c = '0;
                endcase
            end
            FILT_L:
            begin
                case (k)
                    3'd0, 3'd6: c = 10'sd1;
                    3'd1, 3'd5: c = 10'sd6;
                    3'd2, 3'd4: c = 10'sd15;
                    3'd3:       c = 10'sd84;
                    default:    c = '0;
                endcase
            end
            FILT_HS:
            begin
                case (k)
                    3'd1, 3'd4: c = 10'sd16;
                    3'd2, 3'd3: c = 10'sd48;
                    default:    c = '0;
                endcase
            end
            default: c = '0;
        endcase
        return c;
    endfunction

    // Index of tap k around output j, folded or clamped at the line borders.
    function automatic logic [RING_AW-1:0] edge_index(
        input logic [CNT_W-1:0] j,
        input logic [TAP_W-1:0] k,
        input logic [2:0]       sc,
        input logic [CNT_W-1:0] n,
        input logic             known_end,
        input logic             mirror
    );
        logic signed [IDX_W-1:0] idx;
        logic signed [IDX_W-1:0] off;
        logic signed [IDX_W-1:0] top;
        off = (signed'({{(IDX_W-TAP_W){1'b0}}, k}) - IDX_W'(HALF_TAPS)) <<< sc;
        idx = signed'({{(IDX_W-CNT_W){1'b0}}, j}) + off;
        top = signed'({{(IDX_W-CNT_W){1'b0}}, n}) - IDX_W'(1);
        if (idx < 0)
        begin
            idx = mirror ? -idx : '0;
        end
        else if (known_end && idx > top)
        begin
            idx = mirror ? (top <<< 1) - idx : top;
        end
        if (idx < 0)
        begin
            idx = '0;
        end
        if (known_end && idx > top)
        begin
            idx = top;
        end
        return idx[RING_AW-1:0];
    endfunction

endpackage

[src/atdl_ram.sv]
// Generic simple dual-port RAM with a registered read.
module atdl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/atdl_cell.sv]
// One tap cell: holds a sample of the shift chain and its product with the tap.
module atdl_cell (
    input  logic                     clk,
    input  logic                     shift_en,
    input  atdl_pkg::sample_t        sample_in,
    input  atdl_pkg::coef_t          coef,
    output atdl_pkg::sample_t        sample_out,
    output atdl_pkg::value_t         prod
);
    import atdl_pkg::*;

    sample_t sample_reg;
    value_t  prod_reg;
    logic signed [SAMPLE_W+COEF_W-1:0] prod_next;

    assign prod_next = sample_reg * coef;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            sample_reg <= sample_in;
        end
        prod_reg <= prod_next[VALUE_W-1:0];
    end

    assign sample_out = sample_reg;
    assign prod       = prod_reg;

endmodule

[src/a_trous_dilated_line_filter.sv]
// Top level of the dilated 7-tap line filter: control, sample ring, tap cells and adder.
//
//  port group | direction | tdata / tuser contents          | tlast
//  s_axis     | in        | [15:0] sample                   | line_end
//  m_axis     | out       | [24:0] value, [31:25] zero       | last
//  cfg        | in        | cfg_data[2:0] register value    | -
//
// Each sample that releases no output only passes through the idle and check states. For
// every output it releases, the block makes seven ring reads through the single read port,
// waits for the cell products and the two adder stages, then hands over the result.
// Reset clears counters, configuration and handshake state; the ring needs no clear.
// A result still waiting in the output register stalls the next result and, with it, the input.
module a_trous_dilated_line_filter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [24:0] value, [31:25] zero
    output logic        m_axis_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [2:0]  cfg_data
);
    import atdl_pkg::*;

    state_t state_reg, state_next;

    logic [2:0]       filter_select_reg;
    logic [2:0]       scale_reg;
    logic             border_mode_reg;
    logic [CNT_W-1:0] in_count_reg;
    logic [CNT_W-1:0] out_count_reg;
    logic             end_reg;
    logic [2:0]       cnt_reg;
    logic             shift_en_reg;
    logic             out_valid_reg;
    value_t           out_value_reg;
    logic             out_last_reg;
    value_t           s1_reg [4];
    value_t           total_reg;

    logic [2:0]       sc;
    logic [CNT_W:0]   reach_sum;
    logic             more;
    logic             can_load;
    logic             accept;
    logic [RING_AW-1:0] raddr;
    sample_t          rdata;
    sample_t          chain [TAPS+1];
    value_t           prod [TAPS];
    logic             line_end_in;

    assign sc        = (scale_reg > 3'(MAX_SCALE)) ? 3'(MAX_SCALE) : scale_reg;
    assign reach_sum = {1'b0, out_count_reg} + ((CNT_W+1)'(HALF_TAPS) << sc) + (CNT_W+1)'(1);
    assign more      = (out_count_reg < in_count_reg)
                       && (end_reg || reach_sum <= {1'b0, in_count_reg});
    assign can_load  = !out_valid_reg || m_axis_tready;
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign line_end_in = s_axis_tlast || ((in_count_reg + CNT_W'(1)) >= CNT_W'(LINE_MAX));
    assign raddr     = edge_index(out_count_reg, cnt_reg[TAP_W-1:0], sc, in_count_reg,
                                  end_reg, border_mode_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_axis_tvalid) state_next = ST_CHECK;
            ST_CHECK: state_next = more ? ST_READ : ST_IDLE;
            ST_READ:  if (cnt_reg == 3'(TAPS - 1)) state_next = ST_WAIT;
            ST_WAIT:  if (cnt_reg == 3'd3) state_next = ST_OUT;
            ST_OUT:   if (can_load) state_next = ST_CHECK;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        case (state_reg)
            ST_IDLE: s_axis_tready = 1'b1;
            default: s_axis_tready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            filter_select_reg <= '0;
            scale_reg         <= '0;
            border_mode_reg   <= 1'b0;
            in_count_reg      <= '0;
            out_count_reg     <= '0;
            end_reg           <= 1'b0;
            cnt_reg           <= '0;
            shift_en_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            shift_en_reg <= (state_reg == ST_READ);
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FILTER_SELECT: filter_select_reg <= cfg_data;
                    CFG_SCALE:         scale_reg         <= cfg_data;
                    CFG_BORDER_MODE:   border_mode_reg   <= cfg_data[0];
                    default:           ;
                endcase
            end
            if (accept)
            begin
                in_count_reg <= in_count_reg + CNT_W'(1);
                end_reg      <= line_end_in;
            end
            if (state_reg == ST_CHECK && !more && end_reg)
            begin
                in_count_reg  <= '0;
                out_count_reg <= '0;
                end_reg       <= 1'b0;
            end
            if ((state_reg == ST_READ && state_next == ST_WAIT)
                || (state_reg == ST_WAIT && state_next == ST_OUT))
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == ST_READ || state_reg == ST_WAIT)
            begin
                cnt_reg <= cnt_reg + 3'd1;
            end
            if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_OUT && can_load)
            begin
                out_valid_reg <= 1'b1;
                out_count_reg <= out_count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg[0] <= prod[0] + prod[1];
        s1_reg[1] <= prod[2] + prod[3];
        s1_reg[2] <= prod[4] + prod[5];
        s1_reg[3] <= prod[6];
        total_reg <= (s1_reg[0] + s1_reg[1]) + (s1_reg[2] + s1_reg[3]);
        if (state_reg == ST_OUT && can_load)
        begin
            out_value_reg <= total_reg;
            out_last_reg  <= end_reg && ((out_count_reg + CNT_W'(1)) == in_count_reg);
        end
    end

    atdl_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (accept),
        .waddr (in_count_reg[RING_AW-1:0]),
        .wdata (s_axis_tdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign chain[0] = rdata;

    // The first tap read ends up in the last cell.
    for (genvar i = 0; i < TAPS; i++)
    begin : g_cell
        atdl_cell u_cell (
            .clk        (clk),
            .shift_en   (shift_en_reg),
            .sample_in  (chain[i]),
            .coef       (tap_coef(filter_select_reg, TAP_W'(TAPS - 1 - i))),
            .sample_out (chain[i+1]),
            .prod       (prod[i])
        );
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(32-VALUE_W){1'b0}}, out_value_reg};
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (out_count_reg <= in_count_reg))
        else $error("output count ran ahead of input count");
    a_tapcnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (cnt_reg <= 3'(TAPS - 1)))
        else $error("tap counter out of range");
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && can_load) |=> m_axis_tvalid)
        else $error("result load did not raise tvalid");
`endif

endmodule
